// ===== hw/rtl/pfit_pkg.sv =====
`default_nettype none
package pfit_pkg;
	localparam int CAPACITY_DEF = 256;
	localparam int LIMIT_W = 9;
	localparam logic [8:0] LIMIT_RST = 9'd256;
	localparam int COORD_W = 32;
	localparam int POINT_W = 3 * COORD_W;
	localparam int INDEX_W = 8;
	localparam logic [1:0] ADDR_LIMIT = 2'h0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DONE,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input point, clear scan pointer
		logic advance;   // step scan pointer
		logic write;     // append point at fill position
		logic set_hit;   // publish hit result
		logic set_add;   // publish append result
		logic set_full;  // publish full result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_end;  // scan pointer reached fill count
		logic match;     // entry read last cycle equals input
		logic room;      // fill below effective limit
	} dp_sts_t;

	function automatic logic is_nan(input logic [COORD_W-1:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	function automatic logic ieee_eq(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
		if (is_nan(a) || is_nan(b))
			return 1'b0;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			return 1'b1;
		return a == b;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/pfit_ram.sv =====
`default_nettype none
module pfit_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/pfit_datapath.sv =====
`default_nettype none
module pfit_datapath #(
	parameter int CAPACITY = pfit_pkg::CAPACITY_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pfit_pkg::dp_cmd_t              cmd,
	output pfit_pkg::dp_sts_t                   sts,
	input  wire logic [pfit_pkg::POINT_W-1:0]   point_in,
	input  wire logic [pfit_pkg::LIMIT_W-1:0]   entry_limit,
	output logic      [pfit_pkg::INDEX_W-1:0]   res_index,
	output logic                                res_added,
	output logic                                res_full
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > pfit_pkg::LIMIT_W) ? CW : pfit_pkg::LIMIT_W;
	localparam int IW = pfit_pkg::INDEX_W;

	logic [pfit_pkg::POINT_W-1:0] point_q;
	logic [CW-1:0]                fill_q;
	logic [CW-1:0]                ptr_q;     // next address to read
	logic [CW-1:0]                cmp_q;     // address of the data now on rdata
	logic [pfit_pkg::POINT_W-1:0] rdata;
	logic [LW-1:0]                limit_eff;
	logic [LW-1:0]                fill_ext;
	logic [CW:0]                  cmp_ext;

	pfit_ram #(.WIDTH(pfit_pkg::POINT_W), .DEPTH(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(fill_q[AW-1:0]),
		.wdata(point_q),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	assign fill_ext = LW'(fill_q);
	always_comb begin
		if (LW'(entry_limit) < LW'(CAPACITY))
			limit_eff = LW'(entry_limit);
		else
			limit_eff = LW'(CAPACITY);
	end
	assign cmp_ext = {1'b0, cmp_q};

	assign sts.scan_end = (ptr_q == fill_q);
	assign sts.room     = fill_ext < limit_eff;
	assign sts.match    = pfit_pkg::ieee_eq(rdata[31:0], point_q[31:0]) &&
		pfit_pkg::ieee_eq(rdata[63:32], point_q[63:32]) &&
		pfit_pkg::ieee_eq(rdata[95:64], point_q[95:64]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ptr_q  <= '0;
			cmp_q  <= '0;
		end else begin
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.advance) begin
				ptr_q <= ptr_q + CW'(1);
			end
			cmp_q <= ptr_q;
			if (cmd.write)
				fill_q <= fill_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			point_q <= point_in;
		if (cmd.set_hit) begin
			res_index <= IW'(cmp_ext);
			res_added <= 1'b0;
			res_full  <= 1'b0;
		end else if (cmd.set_add) begin
			res_index <= IW'({1'b0, fill_q});
			res_added <= 1'b1;
			res_full  <= 1'b0;
		end else if (cmd.set_full) begin
			res_index <= '0;
			res_added <= 1'b0;
			res_full  <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/pfit_ctrl.sv =====
`default_nettype none
module pfit_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pfit_pkg::dp_cmd_t      cmd,
	input  wire pfit_pkg::dp_sts_t sts
);
	pfit_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pfit_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Scan: READ issues address, CMP checks returned entry while next address goes out.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			pfit_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = pfit_pkg::ST_READ;
				end
			end
			pfit_pkg::ST_READ: begin
				if (sts.scan_end) begin
					state_d = pfit_pkg::ST_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = pfit_pkg::ST_CMP;
				end
			end
			pfit_pkg::ST_CMP: begin
				if (sts.match) begin
					cmd.set_hit = 1'b1;
					state_d     = pfit_pkg::ST_OUT;
				end else if (sts.scan_end) begin
					state_d = pfit_pkg::ST_DONE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			pfit_pkg::ST_DONE: begin
				if (sts.room) begin
					cmd.write   = 1'b1;
					cmd.set_add = 1'b1;
				end else begin
					cmd.set_full = 1'b1;
				end
				state_d = pfit_pkg::ST_OUT;
			end
			pfit_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					in_ready = 1'b1;
					if (in_fire) begin
						cmd.load = 1'b1;
						state_d  = pfit_pkg::ST_READ;
					end else begin
						state_d = pfit_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = pfit_pkg::ST_IDLE;
		endcase
	end

	a_write_only_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> state_q == pfit_pkg::ST_DONE) else $error("append outside done");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.set_hit, cmd.set_add, cmd.set_full}) <= 1) else $error("two results");
	a_out_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.set_hit || cmd.set_add || cmd.set_full) |=> out_valid) else $error("result lost");
endmodule
`default_nettype wire

// ===== hw/rtl/point_find_or_insert_table.sv =====
// Find-or-insert table for 3D points. Each input transfer carries x, y and z
// as single-precision bit patterns; the table is scanned in insertion order
// with IEEE equality per component (+0 equals -0, NaN never matches). A hit
// returns the first matching index; a miss appends the point and returns its
// index, or, once the fill has reached min(entry_limit, CAPACITY), returns
// index 0 with table_full set and stores nothing. One item at a time: an item
// with n stored entries takes one memory read per entry on the registered-read
// scan RAM, plus the append/result step, and the next item is taken in the
// cycle its result is transferred. Reset empties the table and sets
// entry_limit to 256.
`default_nettype none
module point_find_or_insert_table #(
	parameter int CAPACITY = pfit_pkg::CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // point_x, point_y, point_z
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata   // entry_index, newly_added, table_full, 6 zero
);
	logic [pfit_pkg::LIMIT_W-1:0] limit_q;
	logic                         in_fire;
	pfit_pkg::dp_cmd_t            cmd;
	pfit_pkg::dp_sts_t            sts;
	logic [pfit_pkg::INDEX_W-1:0] res_index;
	logic                         res_added;
	logic                         res_full;

	assign pready = 1'b1;

	// Hold the limit register; the host must write it only while no item is in flight; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= pfit_pkg::LIMIT_RST;
		else if (psel && penable && pwrite && paddr == pfit_pkg::ADDR_LIMIT)
			limit_q <= pwdata[pfit_pkg::LIMIT_W-1:0];
	end

	always_comb begin
		unique case (paddr)
			pfit_pkg::ADDR_LIMIT: prdata = {23'd0, limit_q};
			default:              prdata = '0;
		endcase
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	pfit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pfit_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.point_in   (s_axis_tdata),
		.entry_limit(limit_q),
		.res_index  (res_index),
		.res_added  (res_added),
		.res_full   (res_full)
	);

	assign m_axis_tdata = {6'd0, res_full, res_added, res_index};

	a_full_not_added: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res_full && res_added)) else $error("full and added");
	a_full_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_full) |-> res_index == '0) else $error("full index");
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid || !s_axis_tready)
		else $error("ready while busy");
endmodule
`default_nettype wire
